@@ design/kmi_pkg.sv @@
// Shared constants, codes and controller/datapath handshake types for the keyframe interpolator.
`timescale 1ns / 1ps

package kmi_pkg;

   localparam int ELEM_W    = 32;
   localparam int TIME_W    = 24;
   localparam int NEXT_W    = 9;
   localparam int STEP_W    = 16;
   localparam int ELAPSED_W = 16;
   localparam int ADV_W     = STEP_W + ELAPSED_W;
   localparam int FRAC_W    = 25;
   localparam int DIFF_W    = ELEM_W + 1;
   localparam int PROD_W    = DIFF_W + FRAC_W;
   localparam int SUM_W     = PROD_W - 16 + 1;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [TIME_W-1:0] TIME_MAX = 24'hFF_FFFF;
   localparam logic [NEXT_W-1:0] NEXT_MAX = 9'd511;

   // item modes
   localparam logic [2:0] MODE_LOAD  = 3'd0;
   localparam logic [2:0] MODE_TICK  = 3'd1;
   localparam logic [2:0] MODE_PLAY  = 3'd2;
   localparam logic [2:0] MODE_PAUSE = 3'd3;
   localparam logic [2:0] MODE_STOP  = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BONE_COUNT     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEYFRAME_COUNT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_FRAMES     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_STEP     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_ENABLE    = 3'd4;

   localparam logic [4:0]  BONE_COUNT_RST     = 5'd1;
   localparam logic [6:0]  KEYFRAME_COUNT_RST = 7'd0;
   localparam logic [7:0]  MAX_FRAMES_RST     = 8'd0;
   localparam logic [15:0] FRAME_STEP_RST     = 16'd2185;

   typedef struct packed {
      logic accept;   // item taken this cycle
      logic wrap;     // end-of-animation check
      logic check;    // latch fraction and keyframe pair, clear row counter
      logic emit;     // issue one row read
      logic advance;  // step frame time and keyframe index
   } dp_cmd_type;

   typedef struct packed {
      logic emit_ok;
      logic last_row;
      logic pipe_busy;
   } dp_status_type;

endpackage

@@ design/kmi_lerp.sv @@
// One element lane: difference, multiply by fraction, add back and saturate.
`timescale 1ns / 1ps

module kmi_lerp import kmi_pkg::*; (
   input  logic                     clock,
   input  logic signed [ELEM_W-1:0] elem_a,
   input  logic signed [ELEM_W-1:0] elem_b,
   input  logic signed [FRAC_W-1:0] frac,
   output logic signed [ELEM_W-1:0] result
);

   logic signed [DIFF_W-1:0] diff_ff;
   logic signed [ELEM_W-1:0] a1_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ELEM_W-1:0] a2_ff;
   logic signed [ELEM_W-1:0] res_ff;
   logic signed [ELEM_W-1:0] res_in;
   logic        [SUM_W-1:0]  sum;

   always_comb begin
      // floor of the product over 2^16 is the arithmetic shift
      sum = {{(SUM_W-ELEM_W){a2_ff[ELEM_W-1]}}, a2_ff}
          + {prod_ff[PROD_W-1], prod_ff[PROD_W-1:16]};
      if (!sum[SUM_W-1] && (|sum[SUM_W-2:ELEM_W-1])) begin
         res_in = {1'b0, {(ELEM_W-1){1'b1}}};
      end else if (sum[SUM_W-1] && !(&sum[SUM_W-2:ELEM_W-1])) begin
         res_in = {1'b1, {(ELEM_W-1){1'b0}}};
      end else begin
         res_in = sum[ELEM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      diff_ff <= {elem_b[ELEM_W-1], elem_b} - {elem_a[ELEM_W-1], elem_a};
      a1_ff   <= elem_a;
      prod_ff <= diff_ff * frac;
      a2_ff   <= a1_ff;
      res_ff  <= res_in;
   end

   assign result = res_ff;

endmodule

@@ design/kmi_ctrl.sv @@
// Sequencer for tick handling: end check, row emission, time advance.
`timescale 1ns / 1ps

module kmi_ctrl import kmi_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [2:0]    req_mode,
   input  dp_status_type status,
   output dp_cmd_type    cmd,
   output logic          busy
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRAP,
      ST_CHECK,
      ST_EMIT,
      ST_ADVANCE
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      busy       = (state_ff != ST_IDLE) || status.pipe_busy;
      cmd.accept = start && !busy;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.accept && (req_mode == MODE_TICK)) state_in = ST_WRAP;
         end
         ST_WRAP: begin
            cmd.wrap = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = status.emit_ok ? ST_EMIT : ST_ADVANCE;
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            if (status.last_row) state_in = ST_ADVANCE;
         end
         ST_ADVANCE: begin
            cmd.advance = 1'b1;
            state_in    = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ design/kmi_dpath.sv @@
// Keyframe store, playback registers, row addressing and the four lerp lanes.
`timescale 1ns / 1ps

module kmi_dpath import kmi_pkg::*; #(
   parameter int MAX_BONES     = 16,
   parameter int MAX_KEYFRAMES = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  dp_cmd_type                   cmd,
   output dp_status_type                status,
   input  logic [2:0]                   req_mode,
   input  logic [3:0]                   req_bone,
   input  logic [5:0]                   req_frame,
   input  logic [1:0]                   req_row,
   input  logic signed [ELEM_W-1:0]     req_x,
   input  logic signed [ELEM_W-1:0]     req_y,
   input  logic signed [ELEM_W-1:0]     req_z,
   input  logic signed [ELEM_W-1:0]     req_w,
   input  logic [ELAPSED_W-1:0]         req_elapsed,
   input  logic                         csr_write,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_data,
   output logic                         rsp_valid,
   output logic [3:0]                   rsp_out_bone,
   output logic [1:0]                   rsp_out_row,
   output logic signed [ELEM_W-1:0]     rsp_out_x,
   output logic signed [ELEM_W-1:0]     rsp_out_y,
   output logic signed [ELEM_W-1:0]     rsp_out_z,
   output logic signed [ELEM_W-1:0]     rsp_out_w,
   output logic                         rsp_last,
   output logic                         rsp_playing
);

   localparam int BW    = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
   localparam int KW    = $clog2(MAX_KEYFRAMES);
   localparam int CW    = BW + 2;
   localparam int AW    = BW + KW + 2;
   localparam int DEPTH = 1 << AW;
   localparam int ROW_W = 4 * ELEM_W;

   // configuration
   logic [4:0]           bone_count_ff;
   logic [6:0]           keyframe_count_ff;
   logic [7:0]           max_frames_ff;
   logic [STEP_W-1:0]    frame_step_ff;
   logic                 loop_enable_ff;

   // playback state
   logic [TIME_W-1:0]    time_ff, time_in;
   logic [NEXT_W-1:0]    next_ff, next_in;
   logic                 play_ff, play_in;
   logic [ELAPSED_W-1:0] elapsed_ff;
   logic [ADV_W-1:0]     adv_ff;

   // emission
   logic signed [FRAC_W-1:0] frac_ff;
   logic [KW-1:0]        prev_k_ff;
   logic [KW-1:0]        next_k_ff;
   logic [CW-1:0]        cnt_ff;
   logic [NEXT_W-1:0]    prev9;
   logic [4:0]           bc;
   logic [4:0]           bc_m1;
   logic [9:0]           kc;
   logic [ADV_W:0]       nt;
   logic [TIME_W-1:0]    nt_sat;

   // store
   logic [ROW_W-1:0]     mem [DEPTH];
   logic [ROW_W-1:0]     rd_a_ff, rd_b_ff;
   logic [AW-1:0]        wr_addr, rd_addr_a, rd_addr_b;
   logic [8:0]           frame9;
   logic                 load_ok;

   // row pipeline control: after read, after diff, after product
   logic [2:0]           vld_ff;
   logic [CW-1:0]        meta_cnt_ff [3];
   logic [2:0]           meta_last_ff;
   logic                 last_row;
   logic signed [ELEM_W-1:0] lane_res [4];

   always_comb begin
      bc    = (bone_count_ff > 5'(MAX_BONES)) ? 5'(MAX_BONES) : bone_count_ff;
      bc_m1 = bc - 5'd1;
      kc    = (10'(keyframe_count_ff) > 10'(MAX_KEYFRAMES)) ? 10'(MAX_KEYFRAMES)
                                                           : 10'(keyframe_count_ff);
      prev9 = next_ff - 9'd1;
      last_row = (5'(cnt_ff[CW-1:2]) == bc_m1) && (cnt_ff[1:0] == 2'd3);

      status.emit_ok   = ((10'(next_ff) + 10'd1) < kc) && (bc != 5'd0);
      status.last_row  = last_row;
      status.pipe_busy = |vld_ff;

      frame9    = 9'(req_frame);
      load_ok   = (5'(req_bone) < 5'(MAX_BONES)) && (frame9 < 9'(MAX_KEYFRAMES));
      wr_addr   = {req_bone[BW-1:0], frame9[KW-1:0], req_row};
      rd_addr_a = {cnt_ff[CW-1:2], prev_k_ff, cnt_ff[1:0]};
      rd_addr_b = {cnt_ff[CW-1:2], next_k_ff, cnt_ff[1:0]};

      nt     = (ADV_W+1)'(time_ff) + (ADV_W+1)'(adv_ff);
      nt_sat = (nt > (ADV_W+1)'(TIME_MAX)) ? TIME_MAX : nt[TIME_W-1:0];

      time_in = time_ff;
      next_in = next_ff;
      play_in = play_ff;
      if (cmd.accept) begin
         case (req_mode)
            MODE_PLAY:  play_in = 1'b1;
            MODE_PAUSE: play_in = 1'b0;
            MODE_STOP: begin
               play_in = 1'b0;
               time_in = '0;
               next_in = 9'd1;
            end
            default: ;
         endcase
      end else if (cmd.wrap) begin
         if (time_ff >= {max_frames_ff, 16'd0}) begin
            time_in = '0;
            next_in = 9'd1;
            if (!loop_enable_ff) play_in = 1'b0;
         end
      end else if (cmd.advance) begin
         time_in = nt_sat;
         if ((25'(nt_sat) >= {next_ff, 16'd0}) && (next_ff != NEXT_MAX)) begin
            next_in = next_ff + 9'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bone_count_ff     <= BONE_COUNT_RST;
         keyframe_count_ff <= KEYFRAME_COUNT_RST;
         max_frames_ff     <= MAX_FRAMES_RST;
         frame_step_ff     <= FRAME_STEP_RST;
         loop_enable_ff    <= 1'b0;
         time_ff           <= '0;
         next_ff           <= 9'd1;
         play_ff           <= 1'b0;
         cnt_ff            <= '0;
         vld_ff            <= '0;
         rsp_valid         <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_BONE_COUNT:     bone_count_ff     <= csr_data[4:0];
               CSR_KEYFRAME_COUNT: keyframe_count_ff <= csr_data[6:0];
               CSR_MAX_FRAMES:     max_frames_ff     <= csr_data[7:0];
               CSR_FRAME_STEP:     frame_step_ff     <= csr_data;
               CSR_LOOP_ENABLE:    loop_enable_ff    <= csr_data[0];
               default: ;
            endcase
         end
         time_ff <= time_in;
         next_ff <= next_in;
         play_ff <= play_in;
         if (cmd.check) begin
            cnt_ff <= '0;
         end else if (cmd.emit) begin
            cnt_ff <= cnt_ff + CW'(1);
         end
         vld_ff    <= {vld_ff[1:0], cmd.emit};
         rsp_valid <= vld_ff[2];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) elapsed_ff <= req_elapsed;
      adv_ff <= frame_step_ff * elapsed_ff;
      if (cmd.check) begin
         // fraction is non-negative: time never falls below the previous keyframe
         frac_ff   <= FRAC_W'(25'(time_ff) - (25'(prev9[KW-1:0]) << 16));
         prev_k_ff <= prev9[KW-1:0];
         next_k_ff <= next_ff[KW-1:0];
      end
      meta_cnt_ff[0]  <= cnt_ff;
      meta_cnt_ff[1]  <= meta_cnt_ff[0];
      meta_cnt_ff[2]  <= meta_cnt_ff[1];
      meta_last_ff    <= {meta_last_ff[1:0], last_row};
      rsp_out_bone    <= 4'(meta_cnt_ff[2][CW-1:2]);
      rsp_out_row     <= meta_cnt_ff[2][1:0];
      rsp_last        <= meta_last_ff[2];
      rsp_playing     <= play_ff;
   end

   // keyframe store: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (cmd.accept && (req_mode == MODE_LOAD) && load_ok) begin
         mem[wr_addr] <= {req_w, req_z, req_y, req_x};
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   for (genvar e = 0; e < 4; e++) begin : g_lane
      kmi_lerp u_lerp (
         .clock  (clock),
         .elem_a (rd_a_ff[e*ELEM_W +: ELEM_W]),
         .elem_b (rd_b_ff[e*ELEM_W +: ELEM_W]),
         .frac   (frac_ff),
         .result (lane_res[e])
      );
   end

   assign rsp_out_x = lane_res[0];
   assign rsp_out_y = lane_res[1];
   assign rsp_out_z = lane_res[2];
   assign rsp_out_w = lane_res[3];

endmodule

@@ design/keyframe_matrix_interpolator.sv @@
// Top level: per-bone keyframe matrix store with tick-driven row interpolation.
// Load, play, pause and stop words are taken while idle; busy stays low for them.
// A tick emitting rows keeps busy high for end check, setup, emission, advance and drain;
// rows pass the read and lane registers, one per cycle, from the two-port keyframe store.
// A tick that emits nothing keeps busy high for end check, setup and time advance.
// Synchronous reset restores registers, time and keyframe index; the store is not cleared.
`timescale 1ns / 1ps

module keyframe_matrix_interpolator import kmi_pkg::*; #(
   parameter int MAX_BONES     = 16,
   parameter int MAX_KEYFRAMES = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [2:0]               req_mode,
   input  logic [3:0]               req_bone,
   input  logic [5:0]               req_frame,
   input  logic [1:0]               req_row,
   input  logic signed [ELEM_W-1:0] req_x,
   input  logic signed [ELEM_W-1:0] req_y,
   input  logic signed [ELEM_W-1:0] req_z,
   input  logic signed [ELEM_W-1:0] req_w,
   input  logic [ELAPSED_W-1:0]     req_elapsed,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_data,
   output logic                     rsp_valid,
   output logic [3:0]               rsp_out_bone,
   output logic [1:0]               rsp_out_row,
   output logic signed [ELEM_W-1:0] rsp_out_x,
   output logic signed [ELEM_W-1:0] rsp_out_y,
   output logic signed [ELEM_W-1:0] rsp_out_z,
   output logic signed [ELEM_W-1:0] rsp_out_w,
   output logic                     rsp_last,
   output logic                     rsp_playing
);

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   kmi_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_mode),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   kmi_dpath #(
      .MAX_BONES     (MAX_BONES),
      .MAX_KEYFRAMES (MAX_KEYFRAMES)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_mode     (req_mode),
      .req_bone     (req_bone),
      .req_frame    (req_frame),
      .req_row      (req_row),
      .req_x        (req_x),
      .req_y        (req_y),
      .req_z        (req_z),
      .req_w        (req_w),
      .req_elapsed  (req_elapsed),
      .csr_write    (csr_valid && csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .rsp_valid    (rsp_valid),
      .rsp_out_bone (rsp_out_bone),
      .rsp_out_row  (rsp_out_row),
      .rsp_out_x    (rsp_out_x),
      .rsp_out_y    (rsp_out_y),
      .rsp_out_z    (rsp_out_z),
      .rsp_out_w    (rsp_out_w),
      .rsp_last     (rsp_last),
      .rsp_playing  (rsp_playing)
   );

   // a taken tick always makes the block busy
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_mode == MODE_TICK) |=> busy)
      else $error("tick taken without going busy");

   // rows of one tick arrive back to back
   a_rows_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_valid)
      else $error("gap inside a tick's row burst");

   // nothing follows the final row directly
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !rsp_valid)
      else $error("row right after final row");

endmodule
